// ===== src/slfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slfb_pkg;

  // Operating modes of one request
  localparam logic [1:0] MODE_DRAW  = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_SHIFT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PANEL_COUNT    = 2'd0;
  localparam logic [1:0] CFG_PANEL_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_REGISTER_COUNT = 2'd2;
  localparam logic [1:0] CFG_ROTATION       = 2'd3;

  // Rotation codes, quarter turns clockwise
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Panel geometry
  localparam logic [11:0] ROWS       = 12'd24;
  localparam logic [4:0]  HALF_ROWS  = 5'd12;
  localparam logic [4:0]  LAST_ROW   = 5'd23;
  localparam logic [4:0]  ROW_GROUP  = 5'd6;
  localparam logic [4:0]  ROW_FOLD   = 5'd11;
  localparam logic [17:0] BIT_OFFSET = 18'd2;

  // All-on pattern: first and last byte of each 40-bit register carry blank bits
  localparam logic [7:0] PAT_FIRST = 8'hFC;
  localparam logic [7:0] PAT_MID   = 8'hFF;
  localparam logic [7:0] PAT_LAST  = 8'h3F;
  localparam logic [2:0] PHASE_LAST = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               color;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       pixel_dropped;
  } out_res_t;

  function automatic logic [7:0] fill_pattern(input logic [2:0] phase, input logic on);
    logic [7:0] pat;
    if (!on) begin
      pat = 8'h00;
    end else if (phase == 3'd0) begin
      pat = PAT_FIRST;
    end else if (phase == PHASE_LAST) begin
      pat = PAT_LAST;
    end else begin
      pat = PAT_MID;
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== src/segment_lcd_frame_buffer.sv =====
// Bit-mapped frame buffer for chained 24-row segment LCD panels. Each request either draws
// one pixel (mode 0), fills the buffer (mode 1) or returns the next byte to shift out, last
// byte first (mode 2); every request yields exactly one result. A draw runs from acceptance
// through a transform/bounds step, the shared compare-subtract unit dividing the column by
// the panel width, the position and address states forming the bit position, a
// read-modify-write on the single-port buffer RAM and the result state. A draw that falls
// outside the display is dropped in the transform/bounds step, one that lands past the frame
// once its byte address is formed. A fill does one RAM write per byte for T bytes, T being
// min(panel_count * register_count * 10, BUFFER_BYTES). A shift-out does a registered RAM
// read, skipped when T is 0; an unused mode goes straight to its result. Any result can
// wait on out_stall. After reset the RAM is cleared one byte per cycle, all BUFFER_BYTES
// of it, during which in_stall stays high; configuration writes are taken
// throughout. Write the configuration only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module segment_lcd_frame_buffer #(
  parameter int BUFFER_BYTES = 1024
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire slfb_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output slfb_pkg::out_res_t     out_data,
  input  wire                    cfg_we,
  input  wire [1:0]              cfg_index,
  input  wire [6:0]              cfg_data
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_BYTES - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_XFORM,
    S_DIV,
    S_POS,
    S_ADDR,
    S_READ,
    S_MODIFY,
    S_FILL,
    S_SHIFT_RD,
    S_RESP
  } state_t;

  state_t state_r;

  logic [4:0]  pc_r;
  logic [6:0]  pw_r;
  logic [5:0]  rc_r;
  logic [1:0]  rot_r;

  logic [CW-1:0] sp_r;
  logic          restart_r;

  logic signed [15:0] x_r;
  logic signed [15:0] y_r;
  logic               color_r;

  logic [11:0] rem_r;
  logic [4:0]  quo_r;
  logic [2:0]  step_r;
  logic [16:0] base_r;
  logic [3:0]  row_r;
  logic [17:0] pos_r;
  logic [10:0] prod_r;
  logic [2:0]  bit_r;
  logic [2:0]  phase_r;

  logic [AW-1:0] addr_r;
  logic [7:0]    rdata_r;
  logic [7:0]    mem [BUFFER_BYTES];

  logic res_mem_r;
  logic res_bv_r;
  logic res_last_r;
  logic res_drop_r;

  logic               out_valid_r;
  slfb_pkg::out_res_t out_data_r;

  // Geometry derived from the configuration
  logic [10:0]   pcrc;
  logic [14:0]   t_raw;
  logic [CW-1:0] total;
  logic [11:0]   w;
  logic [16:0]   half_base;

  assign pcrc      = 11'(pc_r) * 11'(rc_r);
  assign t_raw     = 15'({pcrc, 3'b000}) + 15'({pcrc, 1'b0});
  assign total     = (t_raw > 15'(BUFFER_BYTES)) ? CW'(BUFFER_BYTES) : CW'(t_raw);
  assign w         = 12'(pw_r) * 12'(pc_r);
  assign half_base = 17'({pcrc, 5'b00000}) + 17'({pcrc, 3'b000});

  // Bounds check, rotation and mirror of the lower rows
  logic [11:0] rw;
  logic [11:0] rh;
  logic        drop_b;
  logic [11:0] px_t;
  logic [4:0]  py_t;
  logic [11:0] px_m;
  logic [4:0]  py_m;
  logic        mirror_b;
  logic [3:0]  row_term;

  always_comb begin
    rw = rot_r[0] ? slfb_pkg::ROWS : w;
    rh = rot_r[0] ? w : slfb_pkg::ROWS;
    drop_b = (w == 12'd0) || x_r[15] || y_r[15] ||
             (x_r[14:0] >= 15'(rw)) || (y_r[14:0] >= 15'(rh));
    case (rot_r)
      slfb_pkg::ROT_90: begin
        px_t = w - 12'd1 - y_r[11:0];
        py_t = x_r[4:0];
      end
      slfb_pkg::ROT_180: begin
        px_t = w - 12'd1 - x_r[11:0];
        py_t = slfb_pkg::LAST_ROW - y_r[4:0];
      end
      slfb_pkg::ROT_270: begin
        px_t = y_r[11:0];
        py_t = slfb_pkg::LAST_ROW - x_r[4:0];
      end
      default: begin
        px_t = x_r[11:0];
        py_t = y_r[4:0];
      end
    endcase
    mirror_b = (py_t >= slfb_pkg::HALF_ROWS);
    if (mirror_b) begin
      py_m = slfb_pkg::LAST_ROW - py_t;
      px_m = w - 12'd1 - px_t;
    end else begin
      py_m = py_t;
      px_m = px_t;
    end
    if (py_m < slfb_pkg::ROW_GROUP) begin
      row_term = 4'(slfb_pkg::ROW_GROUP + py_m);
    end else begin
      row_term = 4'(slfb_pkg::ROW_FOLD - py_m);
    end
  end

  // Shared compare-subtract unit for the column division
  logic [11:0] trial;
  logic        take;
  assign trial = 12'(pw_r) << step_r;
  assign take  = (rem_r >= trial);

  // Column offset: (col/3)*4 + col*12, col/3 by reciprocal (exact for col < 128)
  logic [6:0]  col;
  logic [12:0] col43;
  logic [5:0]  col_div3;
  logic [10:0] col_term;
  assign col      = rem_r[6:0];
  assign col43    = 13'(col) * 13'd43;
  assign col_div3 = col43[12:7];
  assign col_term = 11'({col_div3, 2'b00}) + 11'({col, 3'b000}) + 11'({col, 2'b00});

  logic [16:0] prod40;
  logic [17:0] pos_full;
  logic [14:0] idx;
  assign prod40   = 17'({prod_r, 5'b00000}) + 17'({prod_r, 3'b000});
  assign pos_full = pos_r + 18'(prod40);
  assign idx      = pos_full[17:3];

  // Shift pointer for the next byte
  logic [CW-1:0] sp_eff;
  logic [CW-1:0] sp_dec;
  assign sp_eff = (restart_r || (sp_r == '0) || (sp_r > total)) ? total : sp_r;
  assign sp_dec = sp_eff - CW'(1);

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // Shift-out request that returns a buffer byte
  logic shift_hit;
  assign shift_hit = (in_data.mode == slfb_pkg::MODE_SHIFT) && (total != '0);

  // Buffer RAM write side
  logic       mem_we;
  logic [7:0] mem_wdata;
  logic [7:0] bit_mask;
  assign bit_mask = 8'd1 << bit_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 8'h00;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = slfb_pkg::fill_pattern(phase_r, color_r);
      end
      S_MODIFY: begin
        mem_we    = 1'b1;
        mem_wdata = color_r ? (rdata_r | bit_mask) : (rdata_r & ~bit_mask);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      pc_r        <= 5'd1;
      pw_r        <= 7'd30;
      rc_r        <= 6'd10;
      rot_r       <= slfb_pkg::ROT_0;
      sp_r        <= '0;
      restart_r   <= 1'b1;
      out_valid_r <= 1'b0;
      res_mem_r   <= 1'b0;
      res_bv_r    <= 1'b0;
      res_last_r  <= 1'b0;
      res_drop_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          if (addr_r == LAST_ADDR) begin
            state_r <= S_IDLE;
          end else begin
            addr_r <= addr_r + AW'(1);
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            x_r        <= in_data.x;
            y_r        <= in_data.y;
            color_r    <= in_data.color;
            res_mem_r  <= shift_hit;
            res_bv_r   <= shift_hit;
            res_last_r <= shift_hit && (sp_dec == '0);
            res_drop_r <= 1'b0;
            case (in_data.mode)
              slfb_pkg::MODE_DRAW: begin
                state_r <= S_XFORM;
              end
              slfb_pkg::MODE_FILL: begin
                addr_r  <= '0;
                phase_r <= 3'd0;
                state_r <= (total == '0) ? S_RESP : S_FILL;
              end
              slfb_pkg::MODE_SHIFT: begin
                if (total != '0) begin
                  sp_r       <= sp_dec;
                  addr_r     <= sp_dec[AW-1:0];
                  state_r    <= S_SHIFT_RD;
                end else begin
                  sp_r    <= '0;
                  state_r <= S_RESP;
                end
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end

        S_XFORM: begin
          if (drop_b) begin
            res_drop_r <= 1'b1;
            state_r    <= S_RESP;
          end else begin
            rem_r   <= px_m;
            quo_r   <= 5'd0;
            step_r  <= 3'd4;
            base_r  <= mirror_b ? half_base : 17'd0;
            row_r   <= row_term;
            state_r <= S_DIV;
          end
        end

        S_DIV: begin
          if (take) begin
            rem_r         <= rem_r - trial;
            quo_r[step_r] <= 1'b1;
          end
          if (step_r == 3'd0) begin
            state_r <= S_POS;
          end else begin
            step_r <= step_r - 3'd1;
          end
        end

        S_POS: begin
          pos_r   <= 18'(base_r) + slfb_pkg::BIT_OFFSET + 18'(row_r) + 18'(col_term);
          prod_r  <= 11'(quo_r) * 11'(rc_r);
          state_r <= S_ADDR;
        end

        S_ADDR: begin
          if (idx >= 15'(total)) begin
            res_drop_r <= 1'b1;
            state_r    <= S_RESP;
          end else begin
            addr_r  <= idx[AW-1:0];
            bit_r   <= pos_full[2:0];
            state_r <= S_READ;
          end
        end

        S_READ: begin
          state_r <= S_MODIFY;
        end

        S_MODIFY: begin
          state_r <= S_RESP;
        end

        S_FILL: begin
          if ((CW'(addr_r) + CW'(1)) == total) begin
            state_r <= S_RESP;
          end else begin
            addr_r  <= addr_r + AW'(1);
            phase_r <= (phase_r == slfb_pkg::PHASE_LAST) ? 3'd0 : phase_r + 3'd1;
          end
        end

        S_SHIFT_RD: begin
          state_r <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r                <= 1'b1;
            out_data_r.out_byte        <= res_mem_r ? rdata_r : 8'h00;
            out_data_r.byte_valid      <= res_bv_r;
            out_data_r.last_byte       <= res_last_r;
            out_data_r.pixel_dropped   <= res_drop_r;
            state_r                    <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Any register write restarts the frame
      if (cfg_we) begin
        restart_r <= 1'b1;
        case (cfg_index)
          slfb_pkg::CFG_PANEL_COUNT:    pc_r  <= cfg_data[4:0];
          slfb_pkg::CFG_PANEL_WIDTH:    pw_r  <= cfg_data;
          slfb_pkg::CFG_REGISTER_COUNT: rc_r  <= cfg_data[5:0];
          slfb_pkg::CFG_ROTATION:       rot_r <= cfg_data[1:0];
          default:                      rot_r <= rot_r;
        endcase
      end else if (in_acc && (in_data.mode == slfb_pkg::MODE_SHIFT)) begin
        restart_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (CW'(addr_r) < total))
    else $error("fill address beyond byte count");

  a_modify_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MODIFY) |-> (CW'(addr_r) < total))
    else $error("draw writes beyond byte count");

  a_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_byte) |->
      (out_data_r.byte_valid && !out_data_r.pixel_dropped))
    else $error("last_byte without a buffer byte");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted request did not start");

endmodule

`default_nettype wire

// ===== dv/segment_lcd_frame_buffer_test.sv =====
`timescale 1ns / 1ps

module segment_lcd_frame_buffer_test;

  localparam int BUFFER_BYTES = 1024;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int SETTLE_CYCLES = BUFFER_BYTES + 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  slfb_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  slfb_pkg::out_res_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  segment_lcd_frame_buffer #(.BUFFER_BYTES(BUFFER_BYTES)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the panel buffer and geometry
  logic [7:0] shadow_fb [0:BUFFER_BYTES-1];
  int unsigned shadow_ptr;
  int unsigned shadow_panels;
  int unsigned shadow_width;
  int unsigned shadow_regs;
  logic [1:0] shadow_rot;

  slfb_pkg::in_req_t pending_requests[$];
  slfb_pkg::out_res_t expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_tokens = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;
  int quiet_cycles = 0;
  logic in_taken = 1'b0;

  function automatic int unsigned frame_bytes();
    int unsigned n;
    n = shadow_panels * shadow_regs * 10;
    return (n > BUFFER_BYTES) ? BUFFER_BYTES : n;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < BUFFER_BYTES; i++) shadow_fb[i] = 8'h00;
    shadow_panels = 1;
    shadow_width = 30;
    shadow_regs = 10;
    shadow_rot = slfb_pkg::ROT_0;
    shadow_ptr = frame_bytes();
  endfunction

  function automatic void shadow_write(logic [1:0] idx, logic [6:0] val);
    case (idx)
      slfb_pkg::CFG_PANEL_COUNT: shadow_panels = val[4:0];
      slfb_pkg::CFG_PANEL_WIDTH: shadow_width = val;
      slfb_pkg::CFG_REGISTER_COUNT: shadow_regs = val[5:0];
      default: shadow_rot = val[1:0];
    endcase
    shadow_ptr = frame_bytes();
  endfunction

  // Returns 1 when the pixel falls off the display or past the frame
  function automatic logic plot_pixel(slfb_pkg::in_req_t r);
    int xi, yi, w, rw, rh, px, py;
    int unsigned pos, col, idx;
    xi = $signed(r.x);
    yi = $signed(r.y);
    w = shadow_width * shadow_panels;
    rw = shadow_rot[0] ? 24 : w;
    rh = shadow_rot[0] ? w : 24;
    if (w <= 0 || xi < 0 || yi < 0 || xi >= rw || yi >= rh) return 1'b1;
    case (shadow_rot)
      slfb_pkg::ROT_90: begin
        px = w - 1 - yi;
        py = xi;
      end
      slfb_pkg::ROT_180: begin
        px = w - 1 - xi;
        py = 23 - yi;
      end
      slfb_pkg::ROT_270: begin
        px = yi;
        py = 23 - xi;
      end
      default: begin
        px = xi;
        py = yi;
      end
    endcase
    pos = 0;
    // lower half is folded back into the second half of the chain
    if (py >= 12) begin
      py = 23 - py;
      px = w - 1 - px;
      pos = shadow_panels * shadow_regs * 40;
    end
    pos += (px / shadow_width) * shadow_regs * 40 + 2;
    col = px % shadow_width;
    pos += (col / 3) * 4 + col * 12;
    pos += (py < 6) ? (6 + py) : (11 - py);
    idx = pos >> 3;
    if (idx >= frame_bytes()) return 1'b1;
    if (r.color) shadow_fb[idx] = shadow_fb[idx] | (8'h01 << pos[2:0]);
    else shadow_fb[idx] = shadow_fb[idx] & ~(8'h01 << pos[2:0]);
    return 1'b0;
  endfunction

  function automatic slfb_pkg::out_res_t predict_lcd(slfb_pkg::in_req_t r);
    slfb_pkg::out_res_t res;
    int unsigned t, ph;
    res = '0;
    t = frame_bytes();
    case (r.mode)
      slfb_pkg::MODE_DRAW: res.pixel_dropped = plot_pixel(r);
      slfb_pkg::MODE_FILL: begin
        for (int unsigned i = 0; i < t; i++) begin
          ph = i % 5;
          if (!r.color) shadow_fb[i] = 8'h00;
          else if (ph == 0) shadow_fb[i] = slfb_pkg::PAT_FIRST;
          else if (ph == slfb_pkg::PHASE_LAST) shadow_fb[i] = slfb_pkg::PAT_LAST;
          else shadow_fb[i] = slfb_pkg::PAT_MID;
        end
      end
      slfb_pkg::MODE_SHIFT: begin
        if (shadow_ptr == 0 || shadow_ptr > t) shadow_ptr = t;
        if (t != 0) begin
          shadow_ptr--;
          res.out_byte = shadow_fb[shadow_ptr];
          res.byte_valid = 1'b1;
          res.last_byte = (shadow_ptr == 0);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic slfb_pkg::in_req_t random_request();
    slfb_pkg::in_req_t r;
    int w, rw, rh, pick, sub;
    w = shadow_width * shadow_panels;
    rw = shadow_rot[0] ? 24 : w;
    rh = shadow_rot[0] ? w : 24;
    r.x = 16'($urandom);
    r.y = 16'($urandom);
    r.color = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 60) begin
      r.mode = slfb_pkg::MODE_DRAW;
      sub = $urandom_range(9);
      if (sub < 8) begin
        r.x = 16'($urandom_range(rw + 1));
        r.y = 16'($urandom_range(rh + 1));
      end else if (sub == 8) begin
        r.x = 16'(-$urandom_range(1, 3));
        r.y = 16'($urandom_range(rh));
      end
    end else if (pick < 92) begin
      r.mode = slfb_pkg::MODE_SHIFT;
    end else if (pick < 95) begin
      r.mode = slfb_pkg::MODE_FILL;
    end else begin
      r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  function automatic slfb_pkg::in_req_t make_req(logic [1:0] m, int xv, int yv, logic c);
    slfb_pkg::in_req_t r;
    r.mode = m;
    r.x = 16'(xv);
    r.y = 16'(yv);
    r.color = c;
    return r;
  endfunction

  // Sender: new request only once the previous one was taken
  always @(negedge clk) begin : drive_requests
    logic v;
    if (rst_n && (!in_valid || in_taken)) begin
      v = 1'b0;
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        v = 1'b1;
        in_data <= pending_requests.pop_front();
      end
      in_valid <= v;
    end
  end

  // Receiver, including the long hold-off that backs up the pipeline
  always @(negedge clk) begin : drive_stall
    if (hold_tokens != hold_seen) begin
      hold_seen = hold_tokens;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watch_results
    slfb_pkg::out_res_t exp_res;
    logic req_acc, res_acc;
    req_acc = rst_n && in_valid && !in_stall;
    res_acc = rst_n && out_valid && !out_stall;
    in_taken <= req_acc;
    if (req_acc) expected_results.push_back(predict_lcd(in_data));
    if (res_acc) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result byte=%h valid=%b last=%b dropped=%b", $time,
                 out_data.out_byte, out_data.byte_valid, out_data.last_byte,
                 out_data.pixel_dropped);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.out_byte !== exp_res.out_byte ||
            out_data.byte_valid !== exp_res.byte_valid ||
            out_data.last_byte !== exp_res.last_byte ||
            out_data.pixel_dropped !== exp_res.pixel_dropped) begin
          $display("%0t: mismatch expected %h/%b/%b/%b actual %h/%b/%b/%b",
                   $time, exp_res.out_byte, exp_res.byte_valid, exp_res.last_byte,
                   exp_res.pixel_dropped, out_data.out_byte, out_data.byte_valid,
                   out_data.last_byte, out_data.pixel_dropped);
          errors++;
        end
      end
    end
    if (!rst_n || req_acc || res_acc) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    shadow_write(idx, val);
  endtask

  task automatic run_phase(int phase, int pc, int pw, int rc, int rot, int n, bit squeeze);
    wait_drained();
    write_reg(slfb_pkg::CFG_PANEL_COUNT, 7'(pc));
    write_reg(slfb_pkg::CFG_PANEL_WIDTH, 7'(pw));
    write_reg(slfb_pkg::CFG_REGISTER_COUNT, 7'(rc));
    write_reg(slfb_pkg::CFG_ROTATION, 7'(rot));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (phase % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 45;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 45;
      end
      default: begin
        send_idle_pct = 32;
        recv_stall_pct = 32;
      end
    endcase
    if (squeeze) hold_tokens++;
    for (int i = 0; i < n; i++) pending_requests.push_back(random_request());
  endtask

  initial begin
    shadow_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corners, row-group and half boundaries, bounds and field extremes, then unused, shift and fill
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 0, 0, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 29, 23, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 29, 0, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 0, 23, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 5, 5, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 5, 6, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 0, 11, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 0, 12, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 0, 0, 1'b0));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 30, 0, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 0, 24, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, -1, 0, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 0, -1, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, 32767, 32767, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_DRAW, -32768, -32768, 1'b0));
    pending_requests.push_back(make_req(MODE_UNUSED, -1, -1, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_SHIFT, 0, 0, 1'b0));
    pending_requests.push_back(make_req(slfb_pkg::MODE_SHIFT, 0, 0, 1'b0));
    pending_requests.push_back(make_req(slfb_pkg::MODE_FILL, 0, 0, 1'b1));
    pending_requests.push_back(make_req(slfb_pkg::MODE_SHIFT, 0, 0, 1'b0));
    pending_requests.push_back(make_req(slfb_pkg::MODE_SHIFT, 0, 0, 1'b0));
    pending_requests.push_back(make_req(slfb_pkg::MODE_FILL, 0, 0, 1'b0));
    pending_requests.push_back(make_req(slfb_pkg::MODE_SHIFT, 0, 0, 1'b0));

    run_phase(0, 1, 30, 10, slfb_pkg::ROT_0, 150, 1'b1);
    run_phase(1, 1, 30, 10, slfb_pkg::ROT_90, 140, 1'b0);
    run_phase(2, 2, 30, 10, slfb_pkg::ROT_180, 140, 1'b0);
    run_phase(3, 16, 120, 40, slfb_pkg::ROT_270, 120, 1'b0);
    run_phase(4, 1, 1, 1, slfb_pkg::ROT_0, 150, 1'b0);
    run_phase(5, 3, 7, 2, slfb_pkg::ROT_90, 140, 1'b0);
    run_phase(6, 0, 30, 10, slfb_pkg::ROT_0, 60, 1'b0);
    run_phase(7, 4, 0, 5, slfb_pkg::ROT_180, 60, 1'b0);
    run_phase(8, 2, 30, 0, slfb_pkg::ROT_270, 50, 1'b0);
    run_phase(9, 2, 120, 1, slfb_pkg::ROT_270, 140, 1'b0);
    run_phase(10, 16, 1, 40, slfb_pkg::ROT_90, 140, 1'b0);
    run_phase(11, 5, 12, 3, slfb_pkg::ROT_180, 150, 1'b0);
    run_phase(12, 1, 120, 4, slfb_pkg::ROT_0, 150, 1'b0);
    run_phase(13, 3, 10, 10, slfb_pkg::ROT_270, 140, 1'b0);
    wait_drained();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/slfb_pkg.sv
src/segment_lcd_frame_buffer.sv
dv/segment_lcd_frame_buffer_test.sv
